/* rtl/fmd_pkg.sv */
`timescale 1ns / 1ps

package fmd_pkg;

   localparam int STORE_DEPTH = 16;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [1:0] ST_GOOD     = 2'd0;
   localparam logic [1:0] ST_BAD_SUM  = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;

   // Write port from the parser into the payload memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } fmd_wr_type;

   // Frame completion handed from the parser to the emitter.
   typedef struct packed {
      logic       start;
      logic       burst;
      logic [1:0] status;
      logic [7:0] command;
      logic [7:0] length;
   } fmd_cmd_type;

endpackage

/* rtl/fmd_req_if.sv */
`timescale 1ns / 1ps

interface fmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/fmd_csr_if.sv */
`timescale 1ns / 1ps

interface fmd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/fmd_rsp_if.sv */
`timescale 1ns / 1ps

interface fmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_command;
   logic [7:0] frame_length;
   logic [7:0] payload_byte;
   logic [3:0] payload_index;
   logic       has_payload;
   logic [1:0] frame_status;
   logic       last_of_frame;

   modport source (output valid, output frame_command, output frame_length,
                   output payload_byte, output payload_index, output has_payload,
                   output frame_status, output last_of_frame, input ready);
   modport sink (input valid, input frame_command, input frame_length,
                 input payload_byte, input payload_index, input has_payload,
                 input frame_status, input last_of_frame, output ready);
endinterface

/* rtl/framed_message_deframer_top.sv */
`timescale 1ns / 1ps

// Frame parser for byte streams of the form start, command, length, payload,
// end, checksum. Received bytes enter on the req channel, one per
// transaction; results leave on the rsp channel. The csr channel writes the
// start byte value and is always ready; write it only while the block is idle.
// Header, payload and end bytes are taken one per cycle while no results are
// pending. The checksum byte completes the frame: a status or empty-frame
// result is valid in the cycle after it is accepted, and a good frame streams
// its payload out of the 16-entry payload memory, each item read into a read
// register and then loaded into the output register; a new read is issued only
// once the previous item has left the read register. While results are pending
// req ready is low, so the input is held until every result has been taken.
// When the receiver stalls, the output register holds its item and no further
// reads are issued. Reset returns the parser to hunting for the start byte,
// clears the sum, counters and output valid, and sets the start byte to 0x02.
module framed_message_deframer_top #(
   parameter int MAX_PAYLOAD = 16
) (
   input  logic      clock,
   input  logic      reset,
   fmd_req_if.sink   req_bus,
   fmd_csr_if.sink   csr_bus,
   fmd_rsp_if.source rsp_bus
);
   import fmd_pkg::*;

   localparam int         CAPACITY = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
   localparam logic [7:0] CAP_LEN  = 8'(CAPACITY);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_ETX  = 3'd4;
   localparam logic [2:0] PH_CHK  = 3'd5;

   logic [7:0]  start_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic        req_accept;
   logic        emit_busy;
   logic [7:0]  rx;
   fmd_wr_type  wr;
   fmd_cmd_type cmd;

   assign rx             = req_bus.rx_byte;
   assign req_bus.ready  = !emit_busy;
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign csr_bus.ready  = 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      wr.en      = 1'b0;
      wr.addr    = count_ff[ADDR_W-1:0];
      wr.data    = rx;
      cmd.start   = 1'b0;
      cmd.burst   = 1'b0;
      cmd.status  = ST_GOOD;
      cmd.command = command_ff;
      cmd.length  = length_ff;
      if (req_accept) begin
         unique case (phase_ff)
            PH_CMD: begin
               command_in = rx;
               sum_in     = sum_ff + rx;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               length_in = rx;
               count_in  = '0;
               sum_in    = sum_ff + rx;
               phase_in  = (rx == 8'd0) ? PH_ETX : PH_DATA;
            end
            PH_DATA: begin
               // An over-long frame is still counted and summed, never stored.
               wr.en    = (length_ff <= CAP_LEN);
               sum_in   = sum_ff + rx;
               count_in = count_ff + 8'd1;
               if (count_in >= length_ff) begin
                  phase_in = PH_ETX;
               end
            end
            PH_ETX: begin
               sum_in   = sum_ff + rx;
               phase_in = PH_CHK;
            end
            PH_CHK: begin
               cmd.start = 1'b1;
               if (length_ff > CAP_LEN) begin
                  cmd.status = ST_TOO_LONG;
               end else if (sum_ff != rx) begin
                  cmd.status = ST_BAD_SUM;
               end else begin
                  cmd.status = ST_GOOD;
               end
               cmd.burst = (length_ff > CAP_LEN) ? 1'b0
                         : ((sum_ff == rx) && (length_ff != 8'd0));
               phase_in  = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (rx == start_ff) begin
                  sum_in   = rx;
                  phase_in = PH_CMD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= 8'h02;
         phase_ff   <= PH_HUNT;
         command_ff <= '0;
         length_ff  <= '0;
         count_ff   <= '0;
         sum_ff     <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            start_ff <= csr_bus.data;
         end
         phase_ff   <= phase_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

   fmd_emit u_emit (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .cmd     (cmd),
      .busy    (emit_busy),
      .rsp_bus (rsp_bus)
   );

   // The payload memory is never written while a frame is being read out.
   assert property (@(posedge clock) disable iff (reset) wr.en |-> !emit_busy)
      else $error("payload write during readout");

   // A completed frame always produces results on the following cycles.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && phase_ff == PH_CHK) |=> emit_busy)
      else $error("checksum byte produced no results");

   // Items without payload are always the final item of their frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.has_payload) |-> rsp_bus.last_of_frame)
      else $error("status item not marked last");

   // Nothing follows the last item of a frame until another frame completes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && rsp_bus.last_of_frame) |=> !rsp_bus.valid)
      else $error("result after last item of frame");

endmodule

/* rtl/fmd_emit.sv */
`timescale 1ns / 1ps

module fmd_emit (
   input  logic               clock,
   input  logic               reset,
   input  fmd_pkg::fmd_wr_type  wr,
   input  fmd_pkg::fmd_cmd_type cmd,
   output logic               busy,
   fmd_rsp_if.source          rsp_bus
);
   import fmd_pkg::*;

   logic [7:0]        payload_mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W:0]   remain_ff;
   logic [ADDR_W-1:0] next_addr_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic              pend_ff;
   logic              out_valid_ff;
   logic [7:0]        command_ff;
   logic [7:0]        length_ff;
   logic [7:0]        out_byte_ff;
   logic [3:0]        out_index_ff;
   logic              out_has_ff;
   logic [1:0]        out_status_ff;
   logic              out_last_ff;
   logic              issue;

   // A read goes out only when the output register will be free by the time
   // its data arrives, so nothing ever has to wait in the read pipeline.
   assign issue = (remain_ff != '0) && !pend_ff && (!out_valid_ff || rsp_bus.ready);
   assign busy  = (remain_ff != '0) || pend_ff || out_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         payload_mem[wr.addr] <= wr.data;
      end
      if (issue) begin
         rd_data_ff <= payload_mem[next_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (cmd.start && cmd.burst) begin
            remain_ff <= (ADDR_W + 1)'(cmd.length);
         end else if (issue) begin
            remain_ff <= remain_ff - 1'b1;
         end
         if ((cmd.start && !cmd.burst) || pend_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         next_addr_ff <= '0;
      end else if (issue) begin
         next_addr_ff <= next_addr_ff + 1'b1;
      end
      if (issue) begin
         pend_addr_ff <= next_addr_ff;
      end
      if (cmd.start) begin
         command_ff <= cmd.command;
         length_ff  <= cmd.length;
         if (!cmd.burst) begin
            out_byte_ff   <= '0;
            out_index_ff  <= '0;
            out_has_ff    <= 1'b0;
            out_status_ff <= cmd.status;
            out_last_ff   <= 1'b1;
         end
      end else if (pend_ff) begin
         out_byte_ff   <= rd_data_ff;
         out_index_ff  <= 4'(pend_addr_ff);
         out_has_ff    <= 1'b1;
         out_status_ff <= ST_GOOD;
         out_last_ff   <= (remain_ff == '0);
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.frame_command = command_ff;
   assign rsp_bus.frame_length  = length_ff;
   assign rsp_bus.payload_byte  = out_byte_ff;
   assign rsp_bus.payload_index = out_index_ff;
   assign rsp_bus.has_payload   = out_has_ff;
   assign rsp_bus.frame_status  = out_status_ff;
   assign rsp_bus.last_of_frame = out_last_ff;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import fmd_pkg::*;

   localparam int MAX_PAYLOAD   = 16;
   localparam int PAYLOAD_CAP   = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;
   localparam int RANDOM_ITEMS  = 400;
   localparam int PHASE_ITEMS   = 70;
   localparam int CALM_ITEMS    = 60;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 200;

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_ETX  = 3'd4;
   localparam logic [2:0] PH_CHK  = 3'd5;

   typedef struct packed {
      logic [7:0] command;
      logic [7:0] length;
      logic [7:0] data;
      logic [3:0] index;
      logic       has_data;
      logic [1:0] status;
      logic       last;
   } frame_item_type;

   typedef struct packed {
      bit             is_cfg;
      bit             fixed;
      logic [7:0]     value;
      frame_item_type item;
   } step_row_type;

   localparam frame_item_type NO_ITEM = '0;

   logic clock;
   logic reset;

   fmd_req_if req_bus();
   fmd_csr_if csr_bus();
   fmd_rsp_if rsp_bus();

   framed_message_deframer_top #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .csr_bus(csr_bus),
      .rsp_bus(rsp_bus)
   );

   // Shadow copy of the parser state.
   logic [2:0]   phase        = PH_HUNT;
   logic [7:0]   start_value  = 8'h02;
   logic [7:0]   held_cmd     = '0;
   logic [7:0]   held_len     = '0;
   logic [7:0]   rcv_count    = '0;
   logic [7:0]   run_sum      = '0;
   logic [7:0]   payload_copy [STORE_DEPTH] = '{default: '0};

   frame_item_type items_due [$];
   step_row_type   dir_rows [$];
   int             mismatches     = 0;
   bit             sender_idles   = 1'b0;
   bit             receiver_idles = 1'b0;
   logic           rsp_hold;
   event           long_stall_go;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void parse_byte(input logic [7:0] b);
      frame_item_type item;
      item = '{held_cmd, held_len, 8'h00, 4'd0, 1'b0, ST_GOOD, 1'b1};
      unique case (phase)
         PH_CMD: begin
            held_cmd = b;
            run_sum += b;
            phase = PH_LEN;
         end
         PH_LEN: begin
            held_len = b;
            rcv_count = '0;
            run_sum += b;
            phase = (b == 8'h00) ? PH_ETX : PH_DATA;
         end
         PH_DATA: begin
            // Bytes of an over-long frame still count toward the sum.
            if (rcv_count < STORE_DEPTH && held_len <= PAYLOAD_CAP)
               payload_copy[rcv_count[3:0]] = b;
            run_sum += b;
            rcv_count++;
            if (rcv_count >= held_len) phase = PH_ETX;
         end
         PH_ETX: begin
            run_sum += b;
            phase = PH_CHK;
         end
         PH_CHK: begin
            if (held_len > PAYLOAD_CAP) begin
               item.status = ST_TOO_LONG;
               items_due.push_back(item);
            end else if (run_sum != b) begin
               item.status = ST_BAD_SUM;
               items_due.push_back(item);
            end else if (held_len == 8'h00) begin
               items_due.push_back(item);
            end else begin
               for (int i = 0; i < held_len; i++) begin
                  item.data     = payload_copy[4'(i)];
                  item.index    = 4'(i);
                  item.has_data = 1'b1;
                  item.last     = (i + 1 == held_len);
                  items_due.push_back(item);
               end
            end
            phase = PH_HUNT;
         end
         default: begin
            phase = PH_HUNT;
            if (b == start_value) begin
               run_sum = b;
               phase = PH_CMD;
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
   endtask

   task automatic check_item();
      frame_item_type got;
      frame_item_type want;
      got = '{rsp_bus.frame_command, rsp_bus.frame_length, rsp_bus.payload_byte,
              rsp_bus.payload_index, rsp_bus.has_payload, rsp_bus.frame_status,
              rsp_bus.last_of_frame};
      if (items_due.size() == 0) begin
         report_mismatch($sformatf("result %h arrived with nothing outstanding", got));
         return;
      end
      want = items_due.pop_front();
      check_field("frame_command", got.command, want.command);
      check_field("frame_length", got.length, want.length);
      check_field("payload_byte", got.data, want.data);
      check_field("payload_index", 8'(got.index), 8'(want.index));
      check_field("has_payload", 8'(got.has_data), 8'(want.has_data));
      check_field("frame_status", 8'(got.status), 8'(want.status));
      check_field("last_of_frame", 8'(got.last), 8'(want.last));
   endtask

   // Offers one byte, and once the transaction completes folds it into the
   // shadow parser. A fixed row replaces whatever the shadow produced.
   task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0,
                            input frame_item_type fixed_item = '0);
      int due_now;
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      due_now = items_due.size();
      parse_byte(b);
      if (fixed) begin
         while (items_due.size() > due_now) void'(items_due.pop_back());
         items_due.push_back(fixed_item);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (items_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_start_byte(input logic [7:0] value);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      start_value = value;
   endtask

   initial begin : rsp_sink
      int gap_left;
      gap_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_item();
         if (gap_left > 0) gap_left--;
         else if (receiver_idles && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 4);
         rsp_bus.ready <= !rsp_hold && gap_left == 0;
      end
   end

   initial begin : long_stall
      rsp_hold <= 1'b0;
      @(long_stall_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : stimulus
      int         frame_items;
      int         next_cfg_at;
      int         phase_no;
      int         len;
      logic [7:0] b;
      logic [7:0] sum;
      bit         calm;

      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.data    <= 8'h00;

      // Line noise while hunting.
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      // Empty frame with a good sum, all-ones command and end byte.
      dir_rows.push_back('{1'b0, 1'b0, 8'h02, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'hFF, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'hFF, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b1, 8'h00,
                           '{8'hFF, 8'h00, 8'h00, 4'd0, 1'b0, ST_GOOD, 1'b1}});
      // Checksum mismatch.
      dir_rows.push_back('{1'b0, 1'b0, 8'h02, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h03, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b1, 8'h00,
                           '{8'h00, 8'h00, 8'h00, 4'd0, 1'b0, ST_BAD_SUM, 1'b1}});
      // One payload byte of all ones.
      dir_rows.push_back('{1'b0, 1'b0, 8'h02, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h81, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h01, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'hFF, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h03, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h86, NO_ITEM});
      // The start byte changes after a frame has opened; the sum keeps the old one.
      dir_rows.push_back('{1'b0, 1'b0, 8'h02, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h7E, NO_ITEM});
      dir_rows.push_back('{1'b1, 1'b0, 8'hFF, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h04, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b1, 8'h84,
                           '{8'h7E, 8'h00, 8'h00, 4'd0, 1'b0, ST_GOOD, 1'b1}});
      // The old start byte is now noise; a frame opens on the new one.
      dir_rows.push_back('{1'b0, 1'b0, 8'h02, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'hFF, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h01, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b0, 8'h00, NO_ITEM});
      dir_rows.push_back('{1'b0, 1'b1, 8'h00,
                           '{8'h01, 8'h00, 8'h00, 4'd0, 1'b0, ST_GOOD, 1'b1}});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) set_start_byte(dir_rows[i].value);
         else send_byte(dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].item);
      end

      frame_items = 0;
      next_cfg_at = 0;
      phase_no    = 0;
      while (frame_items < RANDOM_ITEMS) begin
         if (frame_items >= next_cfg_at) begin
            case (phase_no)
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom);
            endcase
            set_start_byte(b);
            // The receiver stops for a while and frames keep coming, so the
            // block backs up and stalls its input.
            if (phase_no == 2) -> long_stall_go;
            phase_no++;
            next_cfg_at += PHASE_ITEMS;
         end
         calm           = frame_items >= RANDOM_ITEMS - CALM_ITEMS;
         sender_idles   = !calm && $urandom_range(0, 3) != 0;
         receiver_idles = !calm && $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 9) == 0) begin
            // Noise never equals the start byte, so the parser stays in hunt.
            repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom);
               if (b == start_value) b = ~b;
               send_byte(b);
            end
         end else begin
            case ($urandom_range(0, 19)) inside
               [0:2]:   len = 0;
               3:       len = PAYLOAD_CAP;
               [4:5]:   len = $urandom_range(9, PAYLOAD_CAP);
               [6:7]:   len = $urandom_range(PAYLOAD_CAP + 1, PAYLOAD_CAP + 8);
               default: len = $urandom_range(1, 8);
            endcase
            sum = start_value;
            send_byte(start_value);
            b = 8'($urandom);
            sum += b;
            send_byte(b);
            b = 8'(len);
            sum += b;
            send_byte(b);
            repeat (len) begin
               b = 8'($urandom);
               sum += b;
               send_byte(b);
            end
            b = 8'($urandom);
            sum += b;
            send_byte(b);
            if ($urandom_range(0, 4) == 0) sum ^= 8'($urandom_range(1, 255));
            send_byte(sum);
            frame_items += len + 5;
         end
      end

      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      wait_drained();
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* framed_message_deframer_top.f */
rtl/fmd_pkg.sv
rtl/fmd_req_if.sv
rtl/fmd_csr_if.sv
rtl/fmd_rsp_if.sv
rtl/fmd_emit.sv
rtl/framed_message_deframer_top.sv
dv/tb_top.sv
